### hdl/pfgrd_pkg.sv
// Shared types, constants and codes of the packed framebuffer draw core.
`default_nettype none
package pfgrd_pkg;

  localparam int FB_BYTES = 262144;
  localparam int FB_AW    = $clog2(FB_BYTES);

  // command codes
  localparam logic [1:0] CMD_FILL  = 2'd0;
  localparam logic [1:0] CMD_RECT  = 2'd1;
  localparam logic [1:0] CMD_GLYPH = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FORMAT = 2'd2;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [10:0] width;
    logic [10:0] height;
    logic [2:0]  format;
  } cfg_t;

  // one unit of work for the back end
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [13:0] x;
    logic signed [13:0] y;
    logic [10:0]        w;
    logic [10:0]        h;
    logic [17:0]        addr;
    logic               last;
  } job_t;

endpackage
`default_nettype wire

### hdl/pfgrd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pfgrd_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic                 re,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]              rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

### hdl/pfgrd_front.sv
// Front end: takes commands and splits glyphs into square jobs.
`default_nettype none
module pfgrd_front import pfgrd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_cmd,
  input  wire logic signed [11:0] in_x_pos,
  input  wire logic signed [11:0] in_y_pos,
  input  wire logic [10:0]        in_rect_w,
  input  wire logic [10:0]        in_rect_h,
  input  wire logic [3:0]         in_scale,
  input  wire logic [34:0]        in_glyph_rows,
  input  wire logic [17:0]        in_read_addr,
  input  wire logic               q_full,
  output logic                    q_push,
  output job_t                    q_job
);
  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_GLYPH = 1'b1;

  logic               state_r, state_nxt;
  logic [34:0]        g_r, g_nxt;
  logic signed [13:0] x_r, x_nxt, y_r, y_nxt;
  logic [3:0]         s_r, s_nxt;
  logic [2:0]         r_r, r_nxt, c_r, c_nxt;
  logic [6:0]         xo_r, xo_nxt, yo_r, yo_nxt;
  logic [4:0]         row;
  logic               bit_set, last_pos;

  assign busy     = (state_r == ST_GLYPH) || q_full;
  assign row      = g_r[4:0];
  assign bit_set  = row[3'd4 - c_r];
  assign last_pos = (r_r == 3'd6) && (c_r == 3'd4);

  always_comb begin
    state_nxt = state_r;
    g_nxt = g_r; x_nxt = x_r; y_nxt = y_r; s_nxt = s_r;
    r_nxt = r_r; c_nxt = c_r; xo_nxt = xo_r; yo_nxt = yo_r;
    q_push = 1'b0;
    q_job  = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start && !q_full) begin
          if (in_cmd == CMD_GLYPH) begin
            state_nxt = ST_GLYPH;
            g_nxt  = in_glyph_rows;
            x_nxt  = 14'(in_x_pos);
            y_nxt  = 14'(in_y_pos);
            s_nxt  = in_scale;
            r_nxt  = '0; c_nxt = '0; xo_nxt = '0; yo_nxt = '0;
          end else begin
            q_push      = 1'b1;
            q_job.kind  = in_cmd;
            q_job.x     = 14'(in_x_pos);
            q_job.y     = 14'(in_y_pos);
            q_job.w     = in_rect_w;
            q_job.h     = in_rect_h;
            q_job.addr  = in_read_addr;
            q_job.last  = 1'b1;
          end
        end
      end
      ST_GLYPH: begin
        // the final cell always sends a job so the command completes
        q_job.kind = CMD_RECT;
        q_job.x    = x_r + $signed({7'd0, xo_r});
        q_job.y    = y_r + $signed({7'd0, yo_r});
        q_job.w    = bit_set ? {7'd0, s_r} : 11'd0;
        q_job.h    = {7'd0, s_r};
        q_job.last = last_pos;
        if (!((bit_set || last_pos) && q_full)) begin
          q_push = bit_set || last_pos;
          if (last_pos) begin
            state_nxt = ST_IDLE;
          end else if (c_r == 3'd4) begin
            c_nxt  = '0;
            r_nxt  = r_r + 3'd1;
            xo_nxt = '0;
            yo_nxt = yo_r + {3'd0, s_r};
            g_nxt  = g_r >> 5;
          end else begin
            c_nxt  = c_r + 3'd1;
            xo_nxt = xo_r + {3'd0, s_r};
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    g_r <= g_nxt; x_r <= x_nxt; y_r <= y_nxt; s_r <= s_nxt;
    r_r <= r_nxt; c_r <= c_nxt; xo_r <= xo_nxt; yo_r <= yo_nxt;
  end
endmodule
`default_nettype wire

### hdl/pfgrd_fifo.sv
// Short job queue between front and back end.
`default_nettype none
module pfgrd_fifo import pfgrd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  job_t      din,
  input  wire logic pop,
  output job_t      dout,
  output logic      full,
  output logic      empty
);
  job_t           mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;

  assign full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
    end
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end
endmodule
`default_nettype wire

### hdl/pfgrd_back.sv
// Back end: clips jobs and walks pixels by read-modify-write on the store; also runs fills and byte reads.
`default_nettype none
module pfgrd_back import pfgrd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  cfg_t       cfg,
  input  wire logic  q_empty,
  input  job_t       q_job,
  output logic       q_pop,
  output logic       out_valid,
  output logic [7:0] out_read_data
);
  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_SETUP = 3'd1;
  localparam logic [2:0] B_MUL   = 3'd2;
  localparam logic [2:0] B_RD    = 3'd3;
  localparam logic [2:0] B_WR    = 3'd4;
  localparam logic [2:0] B_FILL  = 3'd5;
  localparam logic [2:0] B_RDB   = 3'd6;

  localparam logic [21:0]      FB_LIM  = 22'(FB_BYTES);
  localparam logic [FB_AW-1:0] FB_LAST = FB_AW'(FB_BYTES - 1);

  logic [2:0]  st_r, st_nxt;
  job_t        job_r, job_nxt;
  logic [10:0] x0_r, x0_nxt, x1_r, x1_nxt, y1_r, y1_nxt;
  logic [10:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [21:0] rb_r, rb_nxt;
  logic [FB_AW-1:0] fc_r, fc_nxt, wa_r, wa_nxt;
  logic        ok_r, ok_nxt;
  logic        ov_r, ov_nxt;
  logic [7:0]  od_r, od_nxt;

  logic [10:0] stride, xbyte;
  logic [7:0]  white, keep, rdata;
  logic [21:0] addr22;
  logic signed [14:0] xe, ye, pw, ph;
  logic [13:0] x0c, y0c;
  logic [14:0] x1c, y1c;
  logic        we, re;
  logic [FB_AW-1:0] waddr, raddr;
  logic [7:0]  wdata;

  always_comb begin
    if (cfg.format <= 3'd2) begin
      stride = 11'((12'(cfg.width) + 12'd7) >> 3);
      xbyte  = cx_r >> 3;
      keep   = ~(8'h80 >> cx_r[2:0]);
    end else if (cfg.format <= 3'd4) begin
      stride = 11'((12'(cfg.width) + 12'd3) >> 2);
      xbyte  = cx_r >> 2;
      keep   = ~(8'h03 << (3'd6 - {cx_r[1:0], 1'b0}));
    end else begin
      stride = 11'((12'(cfg.width) + 12'd1) >> 1);
      xbyte  = cx_r >> 1;
      keep   = cx_r[0] ? 8'hF0 : 8'h0F;
    end
    case (cfg.format)
      3'd4:         white = 8'h55;
      3'd5, 3'd6:   white = 8'h11;
      default:      white = 8'hFF;
    endcase
  end

  assign addr22 = rb_r + {11'd0, xbyte};
  assign pw = $signed({4'd0, cfg.width});
  assign ph = $signed({4'd0, cfg.height});
  assign xe = $signed({job_r.x[13], job_r.x}) + $signed({4'd0, job_r.w});
  assign ye = $signed({job_r.y[13], job_r.y}) + $signed({4'd0, job_r.h});
  assign x0c = job_r.x[13] ? 14'd0 : job_r.x;
  assign y0c = job_r.y[13] ? 14'd0 : job_r.y;
  assign x1c = (xe > pw) ? pw : (xe[14] ? 15'd0 : xe);
  assign y1c = (ye > ph) ? ph : (ye[14] ? 15'd0 : ye);

  always_comb begin
    st_nxt = st_r; job_nxt = job_r;
    x0_nxt = x0_r; x1_nxt = x1_r; y1_nxt = y1_r;
    cx_nxt = cx_r; cy_nxt = cy_r; rb_nxt = rb_r;
    fc_nxt = fc_r; wa_nxt = wa_r; ok_nxt = ok_r;
    ov_nxt = 1'b0; od_nxt = 8'd0;
    q_pop = 1'b0;
    we = 1'b0; re = 1'b0; waddr = wa_r; raddr = FB_AW'(addr22); wdata = rdata & keep;
    unique case (st_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          job_nxt = q_job;
          fc_nxt  = '0;
          ok_nxt  = 1'b0;
          unique case (q_job.kind)
            CMD_FILL: st_nxt = B_FILL;
            CMD_READ: st_nxt = B_RDB;
            default:  st_nxt = B_SETUP;
          endcase
        end
      end
      B_SETUP: begin
        x0_nxt = x0c[10:0];
        x1_nxt = x1c[10:0];
        y1_nxt = y1c[10:0];
        cx_nxt = x0c[10:0];
        cy_nxt = y0c[10:0];
        if ({1'b0, x0c} >= x1c || {1'b0, y0c} >= y1c) begin
          st_nxt = B_IDLE;
          ov_nxt = job_r.last;
        end else begin
          st_nxt = B_MUL;
        end
      end
      B_MUL: begin
        rb_nxt = 22'(cy_r * stride);
        st_nxt = B_RD;
      end
      B_RD: begin
        wa_nxt = FB_AW'(addr22);
        if (addr22 < FB_LIM) begin
          re     = 1'b1;
          st_nxt = B_WR;
        end else begin
          st_nxt = B_WR;
          ok_nxt = 1'b0;
        end
        if (addr22 < FB_LIM) ok_nxt = 1'b1;
      end
      B_WR: begin
        we = ok_r;
        if (cx_r + 11'd1 < x1_r) begin
          cx_nxt = cx_r + 11'd1;
          st_nxt = B_RD;
        end else if (cy_r + 11'd1 < y1_r) begin
          cy_nxt = cy_r + 11'd1;
          cx_nxt = x0_r;
          rb_nxt = rb_r + {11'd0, stride};
          st_nxt = B_RD;
        end else begin
          st_nxt = B_IDLE;
          ov_nxt = job_r.last;
        end
      end
      B_FILL: begin
        we     = 1'b1;
        waddr  = fc_r;
        wdata  = white;
        fc_nxt = fc_r + 1'b1;
        if (fc_r == FB_LAST) begin
          st_nxt = B_IDLE;
          ov_nxt = job_r.last;
        end
      end
      B_RDB: begin
        // issue the read, then register the returned byte onto the result output
        if (!ok_r && fc_r == '0) begin
          re     = 1'b1;
          raddr  = FB_AW'(job_r.addr);
          ok_nxt = 1'b1;
          fc_nxt = FB_AW'(1);
        end else begin
          ok_nxt = 1'b0;
          st_nxt = B_IDLE;
          ov_nxt = job_r.last;
          od_nxt = (32'(job_r.addr) < 32'(FB_BYTES)) ? rdata : 8'd0;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  pfgrd_ram #(.W(8), .D(FB_BYTES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_valid     = ov_r;
  assign out_read_data = od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      ov_r <= 1'b0;
      ok_r <= 1'b0;
      od_r <= 8'd0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      ok_r <= ok_nxt;
      od_r <= od_nxt;
    end
    job_r <= job_nxt;
    x0_r <= x0_nxt; x1_r <= x1_nxt; y1_r <= y1_nxt;
    cx_r <= cx_nxt; cy_r <= cy_nxt; rb_r <= rb_nxt;
    fc_r <= fc_nxt; wa_r <= wa_nxt;
  end
endmodule
`default_nettype wire

### hdl/packed_framebuffer_glyph_rect_draw_core.sv
// Top level of the packed framebuffer rectangle and glyph draw engine.
// A command is taken when start is high and busy is low; each command gives
// exactly one result, shown for one cycle with out_valid high, which the
// receiver must take as it comes. The front end queues commands (glyphs are
// split into one job per set bit, plus one for a clear last cell) into a
// four-deep queue; the back end runs jobs one pixel at a time, reading each
// clipped pixel's byte in B_RD and writing it back in B_WR, after B_SETUP
// and B_MUL per rectangle. A fill writes every byte of the store. Reads of
// bytes never written since the first fill give undefined data.
`default_nettype none
module packed_framebuffer_glyph_rect_draw_core import pfgrd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_cmd,
  input  wire logic signed [11:0] in_x_pos,
  input  wire logic signed [11:0] in_y_pos,
  input  wire logic [10:0]        in_rect_w,
  input  wire logic [10:0]        in_rect_h,
  input  wire logic [3:0]         in_scale,
  input  wire logic [34:0]        in_glyph_rows,
  input  wire logic [17:0]        in_read_addr,
  output logic                    out_valid,
  output logic [7:0]              out_read_data,
  output logic                    out_cmd_done,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [10:0]        cfg_data
);
  cfg_t cfg_r;
  job_t q_in, q_out;
  logic q_push, q_pop, q_full, q_empty;

  // hold the panel registers; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= 11'd800;
      cfg_r.height <= 11'd480;
      cfg_r.format <= 3'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  cfg_r.width  <= cfg_data;
        REG_HEIGHT: cfg_r.height <= cfg_data;
        REG_FORMAT: cfg_r.format <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  pfgrd_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_x_pos(in_x_pos), .in_y_pos(in_y_pos),
    .in_rect_w(in_rect_w), .in_rect_h(in_rect_h), .in_scale(in_scale),
    .in_glyph_rows(in_glyph_rows), .in_read_addr(in_read_addr),
    .q_full(q_full), .q_push(q_push), .q_job(q_in)
  );

  pfgrd_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(q_push), .din(q_in),
    .pop(q_pop), .dout(q_out), .full(q_full), .empty(q_empty)
  );

  pfgrd_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .q_empty(q_empty), .q_job(q_out),
    .q_pop(q_pop), .out_valid(out_valid), .out_read_data(out_read_data)
  );

  // every transfer marks a completed command
  assign out_cmd_done = out_valid;
endmodule
`default_nettype wire

### hdl/pfgrd_checker.sv
// Port-level checks of the draw core, bound to the top level.
`default_nettype none
module pfgrd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_cmd_done,
  input wire logic [7:0] out_read_data
);
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held two cycles");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cmd_done) else $error("result without done");
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result right after reset");
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> out_read_data == 8'd0) else $error("data without result");
endmodule

bind packed_framebuffer_glyph_rect_draw_core pfgrd_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid),
  .out_cmd_done(out_cmd_done), .out_read_data(out_read_data)
);
`default_nettype wire

### dv/tb_packed_framebuffer_glyph_rect_draw_core.sv
// Self-checking testbench of the packed framebuffer rectangle and glyph draw core.
`default_nettype none
module tb_packed_framebuffer_glyph_rect_draw_core;
  import pfgrd_pkg::*;

  // Give up well past the slowest legal run, which holds three full-store
  // fills as well as the wide rectangles and large glyphs.
  localparam int CYCLE_LIMIT = 12000000;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [1:0]  cmd;
    int          x;
    int          y;
    int          w;
    int          h;
    int          s;
    logic [34:0] glyph;
    logic [17:0] addr;
    bit          typed;  // expected byte given in the table
    logic [7:0]  want;
  } draw_cmd_t;

  typedef struct {
    int         width;
    int         height;
    logic [2:0] format;
    bit         do_fill;
    int         items;
  } phase_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_cmd;
  logic signed [11:0] in_x_pos;
  logic signed [11:0] in_y_pos;
  logic [10:0]        in_rect_w;
  logic [10:0]        in_rect_h;
  logic [3:0]         in_scale;
  logic [34:0]        in_glyph_rows;
  logic [17:0]        in_read_addr;
  logic               out_valid;
  logic [7:0]         out_read_data;
  logic               out_cmd_done;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [10:0]        cfg_data;

  // Predictor state: panel settings and a mirror of the frame store.
  int         pan_w;
  int         pan_h;
  logic [2:0] pix_fmt;
  logic [7:0] frame_img [FB_BYTES];

  logic [7:0] read_byte_q [$];
  int         mismatches;
  int         cycles;
  int         accepted;
  int         n_fill, n_rect, n_glyph, n_read;

  packed_framebuffer_glyph_rect_draw_core u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_x_pos      (in_x_pos),
    .in_y_pos      (in_y_pos),
    .in_rect_w     (in_rect_w),
    .in_rect_h     (in_rect_h),
    .in_scale      (in_scale),
    .in_glyph_rows (in_glyph_rows),
    .in_read_addr  (in_read_addr),
    .out_valid     (out_valid),
    .out_read_data (out_read_data),
    .out_cmd_done  (out_cmd_done),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  function automatic logic [7:0] white_of_format();
    if (pix_fmt == 3'd4) return 8'h55;
    if (pix_fmt == 3'd5 || pix_fmt == 3'd6) return 8'h11;
    return 8'hFF;
  endfunction

  // Clear one pixel to black; skip off-panel pixels, drop writes past the store.
  function automatic void paint_black_pixel(int x, int y);
    int stride;
    int addr;
    if (x < 0 || y < 0 || x >= pan_w || y >= pan_h) return;
    if (pix_fmt <= 3'd2) begin
      stride = (pan_w + 7) / 8;
      addr   = y * stride + x / 8;
      if (addr >= FB_BYTES) return;
      frame_img[addr] &= ~(8'h80 >> (x % 8));
    end else if (pix_fmt <= 3'd4) begin
      stride = (pan_w + 3) / 4;
      addr   = y * stride + x / 4;
      if (addr >= FB_BYTES) return;
      frame_img[addr] &= ~(8'h03 << (6 - (x % 4) * 2));
    end else begin
      stride = (pan_w + 1) / 2;
      addr   = y * stride + x / 2;
      if (addr >= FB_BYTES) return;
      frame_img[addr] &= (x % 2 == 0) ? 8'h0F : 8'hF0;
    end
  endfunction

  function automatic void clear_rect(int x, int y, int w, int h);
    int x0, y0, x1, y1;
    x0 = (x < 0) ? 0 : x;
    y0 = (y < 0) ? 0 : y;
    x1 = (x + w > pan_w) ? pan_w : x + w;
    y1 = (y + h > pan_h) ? pan_h : y + h;
    for (int yy = y0; yy < y1; yy++)
      for (int xx = x0; xx < x1; xx++)
        paint_black_pixel(xx, yy);
  endfunction

  // Work out the command's effect on the store and the byte it returns.
  function automatic logic [7:0] apply_command(draw_cmd_t c);
    logic [4:0] bits;
    logic [7:0] data;
    data = 8'h00;
    case (c.cmd)
      CMD_FILL: begin
        for (int i = 0; i < FB_BYTES; i++) frame_img[i] = white_of_format();
        n_fill++;
      end
      CMD_RECT: begin
        clear_rect(c.x, c.y, c.w, c.h);
        n_rect++;
      end
      CMD_GLYPH: begin
        for (int r = 0; r < 7; r++) begin
          bits = 5'(c.glyph >> (5 * r));
          for (int col = 0; col < 5; col++)
            if (bits[4 - col]) clear_rect(c.x + col * c.s, c.y + r * c.s, c.s, c.s);
        end
        n_glyph++;
      end
      default: begin
        data = frame_img[c.addr];
        n_read++;
      end
    endcase
    return data;
  endfunction

  // ---------------------------------------------------------------------
  // Result checker: results cannot be held off, so take each as it comes
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycles,
                 read_byte_q.size());
        $display("Mismatches found");
        $finish;
      end
      if (out_valid) begin
        if (read_byte_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: read_data %02h done %b", out_read_data,
                     out_cmd_done);
        end else begin
          if (out_read_data !== read_byte_q[0] || out_cmd_done !== 1'b1) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("result mismatch: read_data exp %02h got %02h, done exp 1 got %b",
                       read_byte_q[0], out_read_data, out_cmd_done);
          end
          void'(read_byte_q.pop_front());
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  // Mostly short gaps, a few long ones, and whole stretches with none.
  function automatic int pick_gap(int idx);
    int r;
    if (idx % 100 < 30) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Hold start low for the gap, then present the transfer and wait for it.
  task automatic send_cmd(draw_cmd_t c, int gap);
    logic [7:0] exp_byte;
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start         = 1'b1;
    in_cmd        = c.cmd;
    in_x_pos      = 12'(c.x);
    in_y_pos      = 12'(c.y);
    in_rect_w     = 11'(c.w);
    in_rect_h     = 11'(c.h);
    in_scale      = 4'(c.s);
    in_glyph_rows = c.glyph;
    in_read_addr  = c.addr;
    do @(posedge clk); while (busy);
    exp_byte = apply_command(c);
    read_byte_q.push_back(c.typed ? c.want : exp_byte);
    accepted++;
  endtask

  // Drain every result, let the back end settle, then write the registers.
  task automatic set_panel(int w, int h, logic [2:0] fmt);
    @(negedge clk);
    start = 1'b0;
    while (read_byte_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we = 1'b1; cfg_index = REG_WIDTH;  cfg_data = 11'(w);
    @(negedge clk);
    cfg_index = REG_HEIGHT; cfg_data = 11'(h);
    @(negedge clk);
    cfg_index = REG_FORMAT; cfg_data = 11'(fmt);
    @(negedge clk);
    cfg_we = 1'b0;
    pan_w = w; pan_h = h; pix_fmt = fmt;
  endtask

  function automatic int pick_coord(int span);
    if ($urandom_range(0, 99) < 85) return int'($urandom_range(0, span + 25)) - 20;
    return int'($signed(12'($urandom)));
  endfunction

  // Small sizes keep the run short; a full-range size only along one axis
  // unless the panel itself is tiny.
  function automatic draw_cmd_t make_random_cmd();
    draw_cmd_t c;
    int r;
    int span;
    bit tiny;
    r = $urandom_range(0, 99);
    c.cmd   = (r < 35) ? CMD_RECT : (r < 65) ? CMD_GLYPH : CMD_READ;
    c.x     = pick_coord(pan_w);
    c.y     = pick_coord(pan_h);
    c.w     = $urandom_range(0, 12);
    c.h     = $urandom_range(0, 12);
    tiny    = (pan_w * pan_h <= 4096);
    if ($urandom_range(0, 99) < 8) c.w = $urandom_range(0, 2047);
    else if ($urandom_range(0, 99) < 8) c.h = $urandom_range(0, 2047);
    if (tiny && $urandom_range(0, 9) == 0) begin
      c.w = $urandom_range(0, 2047);
      c.h = $urandom_range(0, 2047);
    end
    c.s     = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3) : $urandom_range(0, 15);
    c.glyph = {3'($urandom), 32'($urandom)};
    span    = ((pix_fmt <= 3'd2) ? (pan_w + 7) / 8 :
               (pix_fmt <= 3'd4) ? (pan_w + 3) / 4 : (pan_w + 1) / 2) * pan_h;
    if (span > FB_BYTES) span = FB_BYTES;
    c.addr  = ($urandom_range(0, 99) < 70) ? 18'($urandom_range(0, span - 1)) : 18'($urandom);
    c.typed = 1'b0;
    c.want  = 8'h00;
    return c;
  endfunction

  function automatic draw_cmd_t row(logic [1:0] cmd, int x, int y, int w, int h, int s,
                                    logic [34:0] g, logic [17:0] a, bit typed,
                                    logic [7:0] want);
    draw_cmd_t c;
    c = '{cmd, x, y, w, h, s, g, a, typed, want};
    return c;
  endfunction

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    draw_cmd_t directed [$];
    draw_cmd_t c;
    phase_t    phases [$];
    int        idx;

    start = 1'b0; in_cmd = CMD_READ; in_x_pos = '0; in_y_pos = '0;
    in_rect_w = '0; in_rect_h = '0; in_scale = '0; in_glyph_rows = '0;
    in_read_addr = '0; cfg_we = 1'b0; cfg_index = REG_WIDTH; cfg_data = '0;
    mismatches = 0; cycles = 0; accepted = 0;
    n_fill = 0; n_rect = 0; n_glyph = 0; n_read = 0;
    pan_w = 800; pan_h = 480; pix_fmt = 3'd0;
    for (int i = 0; i < FB_BYTES; i++) frame_img[i] = 8'h00;

    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part on the reset panel, 800x480 at one bit per pixel.
    // Fill first: no byte may be read before it.
    directed.push_back(row(CMD_FILL,  0, 0, 0, 0, 0, '0, '0, 1'b0, 8'h00));
    directed.push_back(row(CMD_READ,  0, 0, 0, 0, 0, '0, 18'd0, 1'b1, 8'hFF));
    directed.push_back(row(CMD_READ,  0, 0, 0, 0, 0, '0, 18'h3FFFF, 1'b1, 8'hFF));
    // empty rectangles draw nothing
    directed.push_back(row(CMD_RECT,  0, 0, 0, 5, 0, '0, '0, 1'b0, 8'h00));
    directed.push_back(row(CMD_RECT,  0, 0, 5, 0, 0, '0, '0, 1'b0, 8'h00));
    directed.push_back(row(CMD_READ,  0, 0, 0, 0, 0, '0, 18'd0, 1'b1, 8'hFF));
    // wholly off panel at both coordinate extremes
    directed.push_back(row(CMD_RECT, -2048, -2048, 1024, 1024, 0, '0, '0, 1'b0, 8'h00));
    directed.push_back(row(CMD_RECT,  2047,  2047, 1024, 1024, 0, '0, '0, 1'b0, 8'h00));
    directed.push_back(row(CMD_READ,  0, 0, 0, 0, 0, '0, 18'h3FFFF, 1'b1, 8'hFF));
    // clipped at the top-left and bottom-right corners
    directed.push_back(row(CMD_RECT, -3, -2, 8, 4, 0, '0, '0, 1'b0, 8'h00));
    directed.push_back(row(CMD_READ,  0, 0, 0, 0, 0, '0, 18'd0, 1'b0, 8'h00));
    directed.push_back(row(CMD_RECT,  795, 478, 10, 10, 0, '0, '0, 1'b0, 8'h00));
    directed.push_back(row(CMD_READ,  0, 0, 0, 0, 0, '0, 18'd47999, 1'b0, 8'h00));
    // glyphs: all bits, alternating bits off the corner, zero scale, largest scale
    directed.push_back(row(CMD_GLYPH, 10, 10, 0, 0, 1, 35'h7FFFFFFFF, '0, 1'b0, 8'h00));
    directed.push_back(row(CMD_GLYPH, -4, -4, 0, 0, 3, 35'h555555555, '0, 1'b0, 8'h00));
    directed.push_back(row(CMD_GLYPH, 300, 300, 0, 0, 0, 35'h7FFFFFFFF, '0, 1'b0, 8'h00));
    directed.push_back(row(CMD_GLYPH, 700, 400, 0, 0, 15, 35'h000000001, '0, 1'b0, 8'h00));
    directed.push_back(row(CMD_READ,  0, 0, 0, 0, 0, '0, 18'd1001, 1'b0, 8'h00));
    directed.push_back(row(CMD_READ,  0, 0, 0, 0, 0, '0, 18'd1201, 1'b0, 8'h00));
    directed.push_back(row(CMD_READ,  0, 0, 0, 0, 0, '0, 18'd40088, 1'b0, 8'h00));
    directed.push_back(row(CMD_RECT,  100, 100, 1, 1, 0, '0, '0, 1'b0, 8'h00));
    directed.push_back(row(CMD_READ,  0, 0, 0, 0, 0, '0, 18'd10012, 1'b0, 8'h00));
    foreach (directed[i]) send_cmd(directed[i], (i % 3 == 2) ? 2 : 0);

    // Random phases: every format, the panel size extremes, writes past the
    // store on the 1024x1024 four-bit panel, and a fill to each new white.
    phases.push_back('{800, 480, 3'd0, 1'b0, 280});
    phases.push_back('{1, 1, 3'd1, 1'b0, 180});
    phases.push_back('{1024, 1024, 3'd5, 1'b1, 320});
    phases.push_back('{13, 7, 3'd3, 1'b0, 230});
    phases.push_back('{1024, 1024, 3'd4, 1'b1, 280});
    phases.push_back('{333, 200, 3'd6, 1'b0, 250});
    phases.push_back('{77, 1024, 3'd7, 1'b0, 150});
    phases.push_back('{1024, 1, 3'd2, 1'b0, 140});
    idx = 0;
    foreach (phases[p]) begin
      if (p > 0) set_panel(phases[p].width, phases[p].height, phases[p].format);
      if (phases[p].do_fill) begin
        c = make_random_cmd();
        c.cmd = CMD_FILL;
        send_cmd(c, 0);
      end
      for (int i = 0; i < phases[p].items; i++) begin
        send_cmd(make_random_cmd(), pick_gap(idx));
        idx++;
      end
    end

    @(negedge clk);
    start = 1'b0;
    while (read_byte_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d commands: %0d fills, %0d rectangles, %0d glyphs, %0d reads",
             accepted, n_fill, n_rect, n_glyph, n_read);
    $display("over eight panel settings, all eight pixel formats, in %0d cycles", cycles);
    if (mismatches == 0 && read_byte_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, read_byte_q.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
